### hdl/kmt_pkg.sv
// shared widths, operation codes and result status codes of the marker table
`default_nettype none

package kmt_pkg;

    localparam int KEY_W    = 16;
    localparam int POS_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int LARGE_W  = 17;

    typedef logic [1:0]          t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_FRAME  = 2'd1;
    localparam t_mode MODE_TRACK  = 2'd2;
    localparam t_mode MODE_MAX    = 2'd3;

    localparam t_status STATUS_UPDATED  = 3'd0;
    localparam t_status STATUS_APPENDED = 3'd1;
    localparam t_status STATUS_REJECTED = 3'd2;
    localparam t_status STATUS_MATCH    = 3'd3;
    localparam t_status STATUS_NONE     = 3'd4;

endpackage

`default_nettype wire

### hdl/kmt_cell.sv
// one table cell: holds one entry and takes its neighbor's entry on each shift
`default_nettype none

module kmt_cell #(
    parameter int KW = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_shift,
    input  wire logic [2*KW+2*kmt_pkg::POS_W-1:0]  i_data,
    output logic      [2*KW+2*kmt_pkg::POS_W-1:0]  o_data
);

    logic [2*KW+2*kmt_pkg::POS_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_data;
        end
    end

    assign o_data = r_entry;

endmodule

`default_nettype wire

### hdl/keyed_marker_table.sv
// keyed marker table: a ring of entry cells rotated past one compare head
//
// input channel (i_in_valid / o_in_stall): one item carries an operation in
// i_mode (insert or update, query by image, query by track, maxima) with the
// keys and the Q16.16 position. output channel (o_out_valid / i_out_stall):
// result items, one per item except queries, which give every matching entry
// in slot order and set o_last on the final one.
// each item rotates the whole ring of TABLE_DEPTH cells once, one entry past
// the head per cycle unless a result waits on a full output register, then
// passes the finish state, which gives its closing result if it has one, and
// returns to idle; only then is the next item accepted.
// o_in_stall is high while an item is being worked on.
// when the receiver stalls, the output register holds its item and the ring
// stops only when another result has to be emitted.
// reset empties the table (entry count zero) and clears both channels; the
// entries themselves need no clearing.
`default_nettype none

module keyed_marker_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [1:0]                           i_mode,
    input  wire logic [kmt_pkg::KEY_W-1:0]            i_frame_number,
    input  wire logic [kmt_pkg::KEY_W-1:0]            i_track_number,
    input  wire logic signed [kmt_pkg::POS_W-1:0]     i_pos_x,
    input  wire logic signed [kmt_pkg::POS_W-1:0]     i_pos_y,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [kmt_pkg::STATUS_W-1:0]              o_status,
    output logic [kmt_pkg::KEY_W-1:0]                 o_out_frame,
    output logic [kmt_pkg::KEY_W-1:0]                 o_out_track,
    output logic signed [kmt_pkg::POS_W-1:0]          o_out_x,
    output logic signed [kmt_pkg::POS_W-1:0]          o_out_y,
    output logic [kmt_pkg::SLOT_W-1:0]                o_slot_index,
    output logic signed [kmt_pkg::LARGE_W-1:0]        o_largest_frame,
    output logic signed [kmt_pkg::LARGE_W-1:0]        o_largest_track,
    output logic                                      o_last
);

    localparam int KW    = (KEY_BITS < kmt_pkg::KEY_W) ? KEY_BITS : kmt_pkg::KEY_W;
    localparam int PW    = kmt_pkg::POS_W;
    localparam int EW    = 2*KW + 2*PW;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // control
    logic [1:0]        r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_count;
    logic              r_found;
    logic              r_pend_valid;
    logic              r_out_valid;

    // item and scan payload
    kmt_pkg::t_mode    r_mode;
    logic [KW-1:0]     r_fr;
    logic [KW-1:0]     r_tr;
    logic [PW-1:0]     r_px;
    logic [PW-1:0]     r_py;
    logic [KW-1:0]     r_max_fr;
    logic [KW-1:0]     r_max_tr;
    logic [EW-1:0]     r_pend_entry;
    logic [IDX_W-1:0]  r_pend_slot;

    // output register
    kmt_pkg::t_status               r_out_status;
    logic [kmt_pkg::KEY_W-1:0]      r_out_frame;
    logic [kmt_pkg::KEY_W-1:0]      r_out_track;
    logic [PW-1:0]                  r_out_x;
    logic [PW-1:0]                  r_out_y;
    logic [kmt_pkg::SLOT_W-1:0]     r_out_slot;
    logic [kmt_pkg::LARGE_W-1:0]    r_out_lf;
    logic [kmt_pkg::LARGE_W-1:0]    r_out_lt;
    logic                           r_out_last;

    kmt_pkg::t_status               n_out_status;
    logic [kmt_pkg::KEY_W-1:0]      n_out_frame;
    logic [kmt_pkg::KEY_W-1:0]      n_out_track;
    logic [PW-1:0]                  n_out_x;
    logic [PW-1:0]                  n_out_y;
    logic [kmt_pkg::SLOT_W-1:0]     n_out_slot;
    logic [kmt_pkg::LARGE_W-1:0]    n_out_lf;
    logic [kmt_pkg::LARGE_W-1:0]    n_out_lt;
    logic                           n_out_last;

    logic [EW-1:0]     w_cell [TABLE_DEPTH];
    logic [EW-1:0]     w_head_next;
    logic [KW-1:0]     w_head_fr;
    logic [KW-1:0]     w_head_tr;
    logic [CNT_W-1:0]  w_idx_ext;
    logic              w_accept;
    logic              w_active;
    logic              w_fr_eq;
    logic              w_tr_eq;
    logic              w_key_hit;
    logic              w_is_query;
    logic              w_upd;
    logic              w_app;
    logic              w_qhit;
    logic              w_scan_emit;
    logic              w_out_free;
    logic              w_step;
    logic              w_fin_emit;
    logic              w_fin_go;
    logic              w_emit;

    // ring of cells, the head entry sits in cell 0

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_ring
            if (g == TABLE_DEPTH - 1) begin : g_tail
                kmt_cell #(.KW(KW)) u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_step),
                    .i_data  (w_head_next),
                    .o_data  (w_cell[g])
                );
            end else begin : g_body
                kmt_cell #(.KW(KW)) u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_step),
                    .i_data  (w_cell[g+1]),
                    .o_data  (w_cell[g])
                );
            end
        end
    endgenerate

    assign w_head_fr = w_cell[0][EW-1 -: KW];
    assign w_head_tr = w_cell[0][2*PW+KW-1 -: KW];

    // head compare

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_idx_ext   = CNT_W'(r_idx);
    assign w_active    = w_idx_ext < r_count;
    assign w_fr_eq     = w_head_fr == r_fr;
    assign w_tr_eq     = w_head_tr == r_tr;
    assign w_is_query  = (r_mode == kmt_pkg::MODE_FRAME) || (r_mode == kmt_pkg::MODE_TRACK);
    assign w_key_hit   = (r_mode == kmt_pkg::MODE_FRAME) ? w_fr_eq : w_tr_eq;
    assign w_upd       = (r_state == ST_SCAN) && (r_mode == kmt_pkg::MODE_INSERT)
                         && w_active && w_fr_eq && w_tr_eq && !r_found;
    assign w_app       = (r_state == ST_SCAN) && (r_mode == kmt_pkg::MODE_INSERT)
                         && (w_idx_ext == r_count) && !r_found;
    assign w_qhit      = (r_state == ST_SCAN) && w_is_query && w_active && w_key_hit;
    assign w_scan_emit = w_upd || w_app || (w_qhit && r_pend_valid);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = (r_state == ST_SCAN) && (!w_scan_emit || w_out_free);
    assign w_fin_emit  = (r_state == ST_FINISH)
                         && !((r_mode == kmt_pkg::MODE_INSERT) && r_found);
    assign w_fin_go    = (r_state == ST_FINISH) && (!w_fin_emit || w_out_free);
    assign w_emit      = (w_step && w_scan_emit) || (w_fin_go && w_fin_emit);

    always_comb begin
        w_head_next = w_cell[0];
        if (w_upd) begin
            w_head_next = {w_head_fr, w_head_tr, r_px, r_py};
        end else if (w_app) begin
            w_head_next = {r_fr, r_tr, r_px, r_py};
        end
    end

    // next output item

    always_comb begin
        n_out_status = kmt_pkg::STATUS_NONE;
        n_out_frame  = '0;
        n_out_track  = '0;
        n_out_x      = '0;
        n_out_y      = '0;
        n_out_slot   = '0;
        n_out_lf     = '0;
        n_out_lt     = '0;
        n_out_last   = 1'b1;
        if (r_state == ST_SCAN) begin
            if (w_upd || w_app) begin
                n_out_status = w_upd ? kmt_pkg::STATUS_UPDATED : kmt_pkg::STATUS_APPENDED;
                n_out_frame  = kmt_pkg::KEY_W'(r_fr);
                n_out_track  = kmt_pkg::KEY_W'(r_tr);
                n_out_x      = r_px;
                n_out_y      = r_py;
                n_out_slot   = kmt_pkg::SLOT_W'(r_idx);
            end else begin
                n_out_status = kmt_pkg::STATUS_MATCH;
                n_out_frame  = kmt_pkg::KEY_W'(r_pend_entry[EW-1 -: KW]);
                n_out_track  = kmt_pkg::KEY_W'(r_pend_entry[2*PW+KW-1 -: KW]);
                n_out_x      = r_pend_entry[2*PW-1 -: PW];
                n_out_y      = r_pend_entry[PW-1:0];
                n_out_slot   = kmt_pkg::SLOT_W'(r_pend_slot);
                n_out_last   = 1'b0;
            end
        end else if (r_mode == kmt_pkg::MODE_INSERT) begin
            n_out_status = kmt_pkg::STATUS_REJECTED;
            n_out_frame  = kmt_pkg::KEY_W'(r_fr);
            n_out_track  = kmt_pkg::KEY_W'(r_tr);
            n_out_x      = r_px;
            n_out_y      = r_py;
        end else if (r_mode == kmt_pkg::MODE_MAX) begin
            n_out_lf = (r_count == '0) ? '1 : kmt_pkg::LARGE_W'(r_max_fr);
            n_out_lt = (r_count == '0) ? '1 : kmt_pkg::LARGE_W'(r_max_tr);
        end else if (r_pend_valid) begin
            n_out_status = kmt_pkg::STATUS_MATCH;
            n_out_frame  = kmt_pkg::KEY_W'(r_pend_entry[EW-1 -: KW]);
            n_out_track  = kmt_pkg::KEY_W'(r_pend_entry[2*PW+KW-1 -: KW]);
            n_out_x      = r_pend_entry[2*PW-1 -: PW];
            n_out_y      = r_pend_entry[PW-1:0];
            n_out_slot   = kmt_pkg::SLOT_W'(r_pend_slot);
        end
    end

    // sequencer

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_count      <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state      <= ST_SCAN;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_pend_valid <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (w_step) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == IDX_LAST) begin
                            r_state <= ST_FINISH;
                        end
                        if (w_upd || w_app) begin
                            r_found <= 1'b1;
                        end
                        if (w_app) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (w_qhit) begin
                            r_pend_valid <= 1'b1;
                        end
                    end
                end
                ST_FINISH: begin
                    if (w_fin_go) begin
                        r_state      <= ST_IDLE;
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_fr     <= i_frame_number[KW-1:0];
            r_tr     <= i_track_number[KW-1:0];
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_max_fr <= '0;
            r_max_tr <= '0;
        end
        if (w_step && w_active) begin
            if (w_head_fr > r_max_fr) begin
                r_max_fr <= w_head_fr;
            end
            if (w_head_tr > r_max_tr) begin
                r_max_tr <= w_head_tr;
            end
        end
        if (w_step && w_qhit) begin
            r_pend_entry <= w_cell[0];
            r_pend_slot  <= r_idx;
        end
        if (w_emit) begin
            r_out_status <= n_out_status;
            r_out_frame  <= n_out_frame;
            r_out_track  <= n_out_track;
            r_out_x      <= n_out_x;
            r_out_y      <= n_out_y;
            r_out_slot   <= n_out_slot;
            r_out_lf     <= n_out_lf;
            r_out_lt     <= n_out_lt;
            r_out_last   <= n_out_last;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_out_frame     = r_out_frame;
    assign o_out_track     = r_out_track;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_slot_index    = r_out_slot;
    assign o_largest_frame = r_out_lf;
    assign o_largest_track = r_out_lt;
    assign o_last          = r_out_last;

`ifndef SYNTHESIS
    // entry count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond table depth");

    // no held match survives into the idle state
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held match left over after item");

    // an accepted item starts its scan at slot zero
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("scan did not start at slot zero");

    // the ring advances one slot per step until the last slot
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_idx != IDX_LAST)) |=>
            (r_state == ST_SCAN) && (r_idx == $past(r_idx) + 1'b1))
        else $error("scan index did not advance");

    // an append always grows the table by one
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_app) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the table");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// self-checking testbench for the keyed marker table: random driver, monitor and table predictor
module tb;

    localparam int DEPTH       = 64;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        kmt_pkg::t_mode                            mode;
        logic [kmt_pkg::KEY_W-1:0]                 frame;
        logic [kmt_pkg::KEY_W-1:0]                 track;
        logic signed [kmt_pkg::POS_W-1:0]          x;
        logic signed [kmt_pkg::POS_W-1:0]          y;
        bit                                        wait_idle;
    } t_marker_op;

    typedef struct packed {
        kmt_pkg::t_status                          status;
        logic [kmt_pkg::KEY_W-1:0]                 frame;
        logic [kmt_pkg::KEY_W-1:0]                 track;
        logic signed [kmt_pkg::POS_W-1:0]          x;
        logic signed [kmt_pkg::POS_W-1:0]          y;
        logic [kmt_pkg::SLOT_W-1:0]                slot;
        logic signed [kmt_pkg::LARGE_W-1:0]        lf;
        logic signed [kmt_pkg::LARGE_W-1:0]        lt;
        logic                                      last;
    } t_marker_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [1:0]                           i_mode = kmt_pkg::MODE_INSERT;
    logic [kmt_pkg::KEY_W-1:0]            i_frame_number = '0;
    logic [kmt_pkg::KEY_W-1:0]            i_track_number = '0;
    logic signed [kmt_pkg::POS_W-1:0]     i_pos_x = '0;
    logic signed [kmt_pkg::POS_W-1:0]     i_pos_y = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic [kmt_pkg::STATUS_W-1:0]         o_status;
    logic [kmt_pkg::KEY_W-1:0]            o_out_frame;
    logic [kmt_pkg::KEY_W-1:0]            o_out_track;
    logic signed [kmt_pkg::POS_W-1:0]     o_out_x;
    logic signed [kmt_pkg::POS_W-1:0]     o_out_y;
    logic [kmt_pkg::SLOT_W-1:0]           o_slot_index;
    logic signed [kmt_pkg::LARGE_W-1:0]   o_largest_frame;
    logic signed [kmt_pkg::LARGE_W-1:0]   o_largest_track;
    logic                                 o_last;

    keyed_marker_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_frame_number  (i_frame_number),
        .i_track_number  (i_track_number),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_frame     (o_out_frame),
        .o_out_track     (o_out_track),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_slot_index    (o_slot_index),
        .o_largest_frame (o_largest_frame),
        .o_largest_track (o_largest_track),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // predicted table contents
    logic [kmt_pkg::KEY_W-1:0]            tab_frame [DEPTH];
    logic [kmt_pkg::KEY_W-1:0]            tab_track [DEPTH];
    logic signed [kmt_pkg::POS_W-1:0]     tab_x     [DEPTH];
    logic signed [kmt_pkg::POS_W-1:0]     tab_y     [DEPTH];
    int                                   tab_count = 0;

    t_marker_op     pending_ops[$];
    t_marker_result expected_results[$];
    t_marker_op     nxt;
    t_marker_result got;
    t_marker_result want;

    logic in_took = 1'b0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   err_count = 0;
    int   hold_left = 0;
    bit   hold_started = 1'b0;
    int   n_mode [4] = '{0, 0, 0, 0};
    int   n_updated = 0;
    int   n_rejected = 0;
    int   longest_answer = 0;

    function automatic int sender_idle_pct();
        return (n_accepted < 110) ? 38 : (n_accepted < 200) ? 72 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (n_accepted < 110) ? 72 : (n_accepted < 200) ? 38 : 0;
    endfunction

    function automatic logic [kmt_pkg::KEY_W-1:0] pick_key(int pool);
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '1;
        if (r < 3)
            return kmt_pkg::KEY_W'($urandom);
        return kmt_pkg::KEY_W'($urandom_range(pool - 1));
    endfunction

    task automatic add_expected(t_marker_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic queue_op(kmt_pkg::t_mode m, logic [kmt_pkg::KEY_W-1:0] f,
                            logic [kmt_pkg::KEY_W-1:0] t, logic [kmt_pkg::POS_W-1:0] x,
                            logic [kmt_pkg::POS_W-1:0] y, bit w);
        t_marker_op op;
        op.mode = m;
        op.frame = f;
        op.track = t;
        op.x = x;
        op.y = y;
        op.wait_idle = w;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic queue_random_op(bit w);
        int             r;
        kmt_pkg::t_mode m;
        r = $urandom_range(99);
        m = (r < 50) ? kmt_pkg::MODE_INSERT :
            (r < 70) ? kmt_pkg::MODE_FRAME :
            (r < 90) ? kmt_pkg::MODE_TRACK : kmt_pkg::MODE_MAX;
        queue_op(m, pick_key(5), pick_key(16), $urandom, $urandom, w);
    endtask

    task automatic predict_marker_op(kmt_pkg::t_mode mode, logic [kmt_pkg::KEY_W-1:0] fr,
                                     logic [kmt_pkg::KEY_W-1:0] tr,
                                     logic signed [kmt_pkg::POS_W-1:0] px,
                                     logic signed [kmt_pkg::POS_W-1:0] py);
        t_marker_result            r;
        t_marker_result            prev;
        bit                        have_prev;
        int                        hit;
        int                        hits;
        logic [kmt_pkg::KEY_W-1:0] mf;
        logic [kmt_pkg::KEY_W-1:0] mt;
        r = '0;
        r.last = 1'b1;
        have_prev = 1'b0;
        hits = 0;
        n_mode[mode]++;
        case (mode)
            kmt_pkg::MODE_INSERT: begin
                hit = -1;
                for (int i = 0; i < tab_count; i++)
                    if (hit < 0 && tab_frame[i] == fr && tab_track[i] == tr)
                        hit = i;
                r.frame = fr;
                r.track = tr;
                r.x = px;
                r.y = py;
                if (hit >= 0) begin
                    tab_x[hit] = px;
                    tab_y[hit] = py;
                    r.status = kmt_pkg::STATUS_UPDATED;
                    r.slot = kmt_pkg::SLOT_W'(hit);
                    n_updated++;
                end else if (tab_count >= DEPTH) begin
                    r.status = kmt_pkg::STATUS_REJECTED;
                    n_rejected++;
                end else begin
                    tab_frame[tab_count] = fr;
                    tab_track[tab_count] = tr;
                    tab_x[tab_count] = px;
                    tab_y[tab_count] = py;
                    r.status = kmt_pkg::STATUS_APPENDED;
                    r.slot = kmt_pkg::SLOT_W'(tab_count);
                    tab_count++;
                end
                add_expected(r);
            end
            kmt_pkg::MODE_MAX: begin
                r.status = kmt_pkg::STATUS_NONE;
                r.lf = '1;
                r.lt = '1;
                if (tab_count != 0) begin
                    mf = '0;
                    mt = '0;
                    for (int i = 0; i < tab_count; i++) begin
                        if (tab_frame[i] > mf) mf = tab_frame[i];
                        if (tab_track[i] > mt) mt = tab_track[i];
                    end
                    r.lf = {1'b0, mf};
                    r.lt = {1'b0, mt};
                end
                add_expected(r);
            end
            default: begin
                for (int i = 0; i < tab_count; i++) begin
                    if ((mode == kmt_pkg::MODE_FRAME) ? (tab_frame[i] == fr)
                                                      : (tab_track[i] == tr)) begin
                        if (have_prev)
                            add_expected(prev);
                        prev = '0;
                        prev.status = kmt_pkg::STATUS_MATCH;
                        prev.frame = tab_frame[i];
                        prev.track = tab_track[i];
                        prev.x = tab_x[i];
                        prev.y = tab_y[i];
                        prev.slot = kmt_pkg::SLOT_W'(i);
                        have_prev = 1'b1;
                        hits++;
                    end
                end
                if (have_prev) begin
                    prev.last = 1'b1;
                    add_expected(prev);
                end else begin
                    r.status = kmt_pkg::STATUS_NONE;
                    add_expected(r);
                end
                if (hits > longest_answer)
                    longest_answer = hits;
            end
        endcase
    endtask

    task automatic report_mismatch(string field, logic [31:0] seen, logic [31:0] wanted);
        if (err_count < 50)
            $display("%0t: result %0d %s got %h expected %h", $time, n_results, field,
                     seen, wanted);
        err_count++;
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (pending_ops.size() != 0
                    && !(pending_ops[0].wait_idle && expected_results.size() != 0)
                    && (hold_left != 0 || $urandom_range(99) >= sender_idle_pct())) begin
                nxt = pending_ops.pop_front();
                i_in_valid <= 1'b1;
                i_mode <= nxt.mode;
                i_frame_number <= nxt.frame;
                i_track_number <= nxt.track;
                i_pos_x <= nxt.x;
                i_pos_y <= nxt.y;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct());
    end

    // long receiver hold-off, lets the block back up into its input
    always @(posedge i_clk) begin
        if (!hold_started && n_accepted == HOLD_AT) begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check results first, then predict from the item taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_status, o_out_frame, o_out_track, o_out_x, o_out_y, o_slot_index,
                    o_largest_frame, o_largest_track, o_last};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item, status", 32'(got.status), '0);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.frame !== want.frame)
                    report_mismatch("frame", 32'(got.frame), 32'(want.frame));
                if (got.track !== want.track)
                    report_mismatch("track", 32'(got.track), 32'(want.track));
                if (got.x !== want.x)
                    report_mismatch("x", got.x, want.x);
                if (got.y !== want.y)
                    report_mismatch("y", got.y, want.y);
                if (got.slot !== want.slot)
                    report_mismatch("slot", 32'(got.slot), 32'(want.slot));
                if (got.lf !== want.lf)
                    report_mismatch("largest frame", 32'(got.lf), 32'(want.lf));
                if (got.lt !== want.lt)
                    report_mismatch("largest track", 32'(got.lt), 32'(want.lt));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
            n_results <= n_results + 1;
        end
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_marker_op(i_mode, i_frame_number, i_track_number, i_pos_x, i_pos_y);
            n_accepted <= n_accepted + 1;
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        // empty table
        queue_op(kmt_pkg::MODE_MAX, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_FRAME, 16'h0000, 16'hFFFF, 32'h1234_5678, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_TRACK, 16'hFFFF, 16'h0000, 32'h0, 32'h8765_4321, 1'b0);
        // key and position extremes
        queue_op(kmt_pkg::MODE_INSERT, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_op(kmt_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_op(kmt_pkg::MODE_INSERT, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_op(kmt_pkg::MODE_INSERT, 16'hFFFF, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        // update in place
        queue_op(kmt_pkg::MODE_INSERT, 16'h0000, 16'h0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
        queue_op(kmt_pkg::MODE_MAX, 16'h5555, 16'hAAAA, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_FRAME, 16'h0000, 16'h1111, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_FRAME, 16'hFFFF, 16'h0000, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_TRACK, 16'h2222, 16'hFFFF, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_TRACK, 16'hFFFF, 16'h0000, 32'h0, 32'h0, 1'b0);
        // no match
        queue_op(kmt_pkg::MODE_FRAME, 16'h1234, 16'h0000, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_TRACK, 16'h0000, 16'h1234, 32'h0, 32'h0, 1'b0);
        queue_op(kmt_pkg::MODE_INSERT, 16'h0007, 16'h0009, $urandom, $urandom, 1'b0);
        queue_op(kmt_pkg::MODE_MAX, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0);

        for (int k = 0; k < 80; k++)
            queue_random_op(k == 0);
        // distinct keys, fills the table for sure
        for (int k = 0; k < 60; k++)
            queue_op(kmt_pkg::MODE_INSERT, pick_key(5), kmt_pkg::KEY_W'(1000 + k),
                     $urandom, $urandom, k == 0);
        for (int k = 0; k < 110; k++)
            queue_random_op(k == 0 || k == 55);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d items: %0d inserts (%0d updates, %0d rejected on a full table),",
                 n_accepted, n_mode[kmt_pkg::MODE_INSERT], n_updated, n_rejected);
        $display("%0d image queries, %0d track queries, %0d maxima, %0d results, longest answer %0d",
                 n_mode[kmt_pkg::MODE_FRAME], n_mode[kmt_pkg::MODE_TRACK],
                 n_mode[kmt_pkg::MODE_MAX], n_results, longest_answer);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
